[rtl/core/scld_pkg.sv]
// Shared types, constants and lookup functions for the serial command line decoder.
`timescale 1ns / 1ps
`default_nettype none

package scld_pkg;

    localparam int MAX_LINE = 100;
    localparam int LEN_W    = $clog2(MAX_LINE);
    localparam int NUM_KW   = 6;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    localparam logic [2:0] CMD_GET_EPOCH  = 3'd0;
    localparam logic [2:0] CMD_READ_CLOCK = 3'd1;
    localparam logic [2:0] CMD_SET_CLOCK  = 3'd2;
    localparam logic [2:0] CMD_SAMPLE     = 3'd3;
    localparam logic [2:0] CMD_START      = 3'd4;
    localparam logic [2:0] CMD_STOP       = 3'd5;
    localparam logic [2:0] CMD_NONE       = 3'd6;

    localparam logic [1:0] TS_NONE = 2'd0;
    localparam logic [1:0] TS_OK   = 2'd1;
    localparam logic [1:0] TS_BAD  = 2'd2;

    localparam logic [3:0] ARG_FULL  = 4'd14;
    localparam logic [3:0] ARG_ENDED = 4'd15;

    localparam logic [13:0] YEAR_MIN = 14'd1970;
    localparam logic [13:0] YEAR_MAX = 14'd2105;
    localparam logic [7:0]  YO_2100  = 8'd130;

    localparam logic signed [17:0] DAY_SECS = 18'sd86400;

    // Keyword text is right-justified ASCII: the first character sits highest.
    localparam logic [127:0] KW_TEXT [NUM_KW] = '{
        128'h4745_545F_4550_4F43_485F_4556_454E_5453,
        128'h52_4541_445F_4441_5445_5449_4D45,
        128'h5345_545F_4441_5445_5449_4D45,
        128'h5341_4D50_4C45,
        128'h53_5441_5254,
        128'h5354_4F50
    };
    localparam logic [4:0] KW_LEN [NUM_KW] = '{5'd16, 5'd13, 5'd12, 5'd6, 5'd5, 5'd4};

    typedef enum logic [1:0] {
        PH_SKIP_LEAD = 2'd0,
        PH_COMMAND   = 2'd1,
        PH_SKIP_ARG  = 2'd2,
        PH_ARGUMENT  = 2'd3
    } scld_phase_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CALC_A = 2'd1,
        ST_CALC_B = 2'd2,
        ST_FINISH = 2'd3
    } scld_state_t;

    typedef struct packed {
        logic byte_en;
        logic calc_a;
        logic calc_b;
        logic finish;
    } scld_cmd_t;

    typedef struct packed {
        logic is_term;
        logic out_free;
    } scld_stat_t;

    function automatic logic kw_hit(logic [2:0] k, logic [4:0] pos, logic [7:0] c);
        logic [4:0]   len;
        logic [127:0] txt;
        logic [3:0]   idx;
        logic [7:0]   ch;
        len = KW_LEN[k];
        txt = KW_TEXT[k];
        idx = 4'(len - 5'd1 - pos);
        ch  = 8'(txt >> {idx, 3'b000});
        return (pos < len) && (ch == c);
    endfunction

    function automatic logic [8:0] days_before_month(logic [6:0] m);
        logic [8:0] d;
        case (m)
            7'd1:    d = 9'd0;
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/scld_ctrl.sv]
// Controller state machine sequencing byte parsing and line-end time arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module scld_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire scld_pkg::scld_stat_t stat,
    output scld_pkg::scld_cmd_t     cmd
);

    scld_pkg::scld_state_t state_reg;
    scld_pkg::scld_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scld_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            scld_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (stat.is_term)
                    begin
                        state_next = scld_pkg::ST_CALC_A;
                    end
                    else
                    begin
                        cmd.byte_en = 1'b1;
                    end
                end
            end
            scld_pkg::ST_CALC_A:
            begin
                cmd.calc_a = 1'b1;
                state_next = scld_pkg::ST_CALC_B;
            end
            scld_pkg::ST_CALC_B:
            begin
                cmd.calc_b = 1'b1;
                state_next = scld_pkg::ST_FINISH;
            end
            scld_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = scld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scld_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/scld_datapath.sv]
// Datapath: token parsing registers, epoch arithmetic and the output register.
`timescale 1ns / 1ps
`default_nettype none

module scld_datapath
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          rx_byte,
    input  wire scld_pkg::scld_cmd_t cmd,
    output scld_pkg::scld_stat_t     stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               out_command,
    output logic [1:0]               out_time_status,
    output logic [31:0]              out_unix_time,
    output logic                     out_line_overflow
);

    localparam int LW = scld_pkg::LEN_W;

    logic [5:0]            flags_reg, flags_next;
    logic [4:0]            pos_reg, pos_next;
    scld_pkg::scld_phase_t phase_reg, phase_next;
    logic [3:0]            cnt_reg, cnt_next;
    logic [6:0]            hour_reg, hour_next;
    logic [6:0]            min_reg, min_next;
    logic [6:0]            sec_reg, sec_next;
    logic [6:0]            day_reg, day_next;
    logic [6:0]            mon_reg, mon_next;
    logic [13:0]           year_reg, year_next;
    logic                  bad_reg, bad_next;
    logic [LW-1:0]         len_reg, len_next;
    logic                  ovf_reg, ovf_next;

    logic signed [17:0]    days_reg;
    logic [18:0]           hms_reg;
    logic signed [35:0]    prod_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_command_reg;
    logic [1:0]            out_status_reg;
    logic [31:0]           out_unix_reg;
    logic                  out_ovf_reg;

    logic                  is_eq;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [5:0]            hit_vec;
    logic                  kw_feed;
    logic                  arg_feed;

    logic [7:0]            yo;
    logic [8:0]            yo_inc;
    logic [5:0]            leaps;
    logic                  leap_year;
    logic [16:0]           day_sum;
    logic signed [17:0]    days_next;
    logic [18:0]           hms_next;
    logic signed [35:0]    prod_next;
    logic signed [36:0]    t_sum;

    logic [2:0]            res_command;
    logic [1:0]            res_status;
    logic                  arg_ok;
    logic                  t_ok;

    assign is_eq    = (rx_byte == scld_pkg::CHAR_EQ);
    assign is_digit = (rx_byte >= scld_pkg::CHAR_0) && (rx_byte <= scld_pkg::CHAR_9);
    assign digit    = 4'(rx_byte - scld_pkg::CHAR_0);

    assign stat.is_term  = (rx_byte == scld_pkg::CHAR_CR) || (rx_byte == scld_pkg::CHAR_LF);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < scld_pkg::NUM_KW; k++)
        begin
            hit_vec[k] = scld_pkg::kw_hit(3'(k), pos_reg, rx_byte);
        end
    end

    // Byte-level parsing of the command and argument tokens.
    always_comb
    begin
        flags_next = flags_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        bad_next   = bad_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        kw_feed    = 1'b0;
        arg_feed   = 1'b0;

        if (cmd.finish)
        begin
            flags_next = '1;
            pos_next   = '0;
            phase_next = scld_pkg::PH_SKIP_LEAD;
            cnt_next   = '0;
            hour_next  = '0;
            min_next   = '0;
            sec_next   = '0;
            day_next   = '0;
            mon_next   = '0;
            year_next  = '0;
            bad_next   = 1'b0;
            len_next   = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.byte_en && !ovf_reg)
        begin
            if (len_reg >= LW'(scld_pkg::MAX_LINE - 1))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
                case (phase_reg)
                    scld_pkg::PH_SKIP_LEAD:
                    begin
                        if (!is_eq)
                        begin
                            phase_next = scld_pkg::PH_COMMAND;
                            kw_feed    = 1'b1;
                        end
                    end
                    scld_pkg::PH_COMMAND:
                    begin
                        if (is_eq)
                        begin
                            phase_next = scld_pkg::PH_SKIP_ARG;
                        end
                        else
                        begin
                            kw_feed = 1'b1;
                        end
                    end
                    scld_pkg::PH_SKIP_ARG:
                    begin
                        if (!is_eq)
                        begin
                            phase_next = scld_pkg::PH_ARGUMENT;
                            arg_feed   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (cnt_reg != scld_pkg::ARG_ENDED)
                        begin
                            if (is_eq)
                            begin
                                if (cnt_reg != scld_pkg::ARG_FULL)
                                begin
                                    bad_next = 1'b1;
                                end
                                cnt_next = scld_pkg::ARG_ENDED;
                            end
                            else
                            begin
                                arg_feed = 1'b1;
                            end
                        end
                    end
                endcase

                if (kw_feed)
                begin
                    flags_next = flags_reg & hit_vec;
                    if (pos_reg != 5'd31)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end

                if (arg_feed)
                begin
                    if (cnt_reg >= scld_pkg::ARG_FULL)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (!is_digit)
                    begin
                        bad_next = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        if (cnt_reg < 4'd2)
                        begin
                            hour_next = 7'(hour_reg * 7'd10 + 7'(digit));
                        end
                        else if (cnt_reg < 4'd4)
                        begin
                            min_next = 7'(min_reg * 7'd10 + 7'(digit));
                        end
                        else if (cnt_reg < 4'd6)
                        begin
                            sec_next = 7'(sec_reg * 7'd10 + 7'(digit));
                        end
                        else if (cnt_reg < 4'd8)
                        begin
                            day_next = 7'(day_reg * 7'd10 + 7'(digit));
                        end
                        else if (cnt_reg < 4'd10)
                        begin
                            mon_next = 7'(mon_reg * 7'd10 + 7'(digit));
                        end
                        else
                        begin
                            year_next = 14'(year_reg * 14'd10 + 14'(digit));
                        end
                    end
                end
            end
        end
    end

    // Day count from 1970 and the time of day; only meaningful for an in-range argument.
    always_comb
    begin
        yo        = 8'(year_reg - scld_pkg::YEAR_MIN);
        yo_inc    = {1'b0, yo} + 9'd1;
        leaps     = 6'(yo_inc >> 2) - 6'(yo > scld_pkg::YO_2100);
        leap_year = (yo[1:0] == 2'd2) && (yo != scld_pkg::YO_2100);
        day_sum   = 17'(yo) * 17'd365 + 17'(leaps)
                  + 17'(scld_pkg::days_before_month(mon_reg))
                  + 17'((mon_reg > 7'd2) && leap_year) + 17'(day_reg);
        days_next = $signed({1'b0, day_sum}) - 18'sd1;
        hms_next  = 19'(hour_reg) * 19'd3600 + 19'(min_reg) * 19'd60 + 19'(sec_reg);
        prod_next = days_reg * scld_pkg::DAY_SECS;
        t_sum     = $signed({prod_reg[35], prod_reg}) + $signed({18'b0, hms_reg});
    end

    always_comb
    begin
        res_command = scld_pkg::CMD_NONE;
        if (!ovf_reg && (phase_reg != scld_pkg::PH_SKIP_LEAD))
        begin
            for (int k = scld_pkg::NUM_KW - 1; k >= 0; k--)
            begin
                if (flags_reg[k] && (scld_pkg::KW_LEN[k] == pos_reg))
                begin
                    res_command = 3'(k);
                end
            end
        end
        arg_ok = (phase_reg == scld_pkg::PH_ARGUMENT) && !bad_reg
               && (cnt_reg >= scld_pkg::ARG_FULL)
               && (mon_reg >= 7'd1) && (mon_reg <= 7'd12)
               && (year_reg >= scld_pkg::YEAR_MIN) && (year_reg <= scld_pkg::YEAR_MAX);
        t_ok   = !t_sum[36] && (t_sum[35:32] == 4'd0);
        res_status = scld_pkg::TS_NONE;
        if (res_command == scld_pkg::CMD_SET_CLOCK)
        begin
            res_status = (arg_ok && t_ok) ? scld_pkg::TS_OK : scld_pkg::TS_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '1;
            pos_reg       <= '0;
            phase_reg     <= scld_pkg::PH_SKIP_LEAD;
            cnt_reg       <= '0;
            hour_reg      <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            day_reg       <= '0;
            mon_reg       <= '0;
            year_reg      <= '0;
            bad_reg       <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            flags_reg <= flags_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            day_reg   <= day_next;
            mon_reg   <= mon_next;
            year_reg  <= year_next;
            bad_reg   <= bad_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_a)
        begin
            days_reg <= days_next;
            hms_reg  <= hms_next;
        end
        if (cmd.calc_b)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.finish)
        begin
            out_command_reg <= res_command;
            out_status_reg  <= res_status;
            out_unix_reg    <= (res_status == scld_pkg::TS_OK) ? t_sum[31:0] : 32'd0;
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_command       = out_command_reg;
    assign out_time_status   = out_status_reg;
    assign out_unix_time     = out_unix_reg;
    assign out_line_overflow = out_ovf_reg;

endmodule

`default_nettype wire

[rtl/core/serial_command_line_decoder.sv]
// Top level of the serial command line decoder: stream ports, controller and datapath.
//
//   Port group   Direction   Word contents
//   s_axis_*     in          one received byte per word
//   m_axis_*     out         one decoded command per line ending
//
// An ordinary byte is taken whenever the controller is idle. A CR or LF is taken in
// the idle state; the line-end arithmetic then runs in CALC_A (day count), CALC_B
// (an 18x18 multiply) and FINISH (final add and range check), which loads the result
// into the output register; the next byte is taken in the cycle after that. A stalled
// output holds the block only at the load step of the next line end.
// Reset clears the parse state and the output valid flag at once.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_line_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [2:0] command, [4:3] time_status,
                                             // [36:5] unix_time, [37] line_overflow
);

    scld_pkg::scld_cmd_t  cmd;
    scld_pkg::scld_stat_t stat;
    logic [2:0]           command;
    logic [1:0]           time_status;
    logic [31:0]          unix_time;
    logic                 line_overflow;

    scld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scld_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_byte           (s_axis_tdata),
        .cmd               (cmd),
        .stat              (stat),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_command       (command),
        .out_time_status   (time_status),
        .out_unix_time     (unix_time),
        .out_line_overflow (line_overflow)
    );

    assign m_axis_tdata = {2'b00, line_overflow, unix_time, time_status, command};

endmodule

`default_nettype wire

[tb/tb_serial_command_line_decoder.sv]
// Self-checking testbench for the serial command line decoder, with its own line predictor.
`timescale 1ns / 1ps

module tb_serial_command_line_decoder;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1450;

    class line_scoreboard;

        typedef struct {
            logic [2:0]  command;
            logic [1:0]  status;
            logic [31:0] seconds;
            logic        overflow;
        } line_result_t;

        line_result_t expected_lines[$];
        int           errors;

        logic [scld_pkg::NUM_KW-1:0] kw_alive;
        int                          tok_pos;
        scld_pkg::scld_phase_t       phase;
        int                          digit_cnt;
        int                          hh, mi, ss, dd, mo, yy;
        bit                          arg_bad;
        int                          line_len;
        bit                          overflowed;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function string keyword(int k);
            string        s;
            logic [127:0] txt;
            int           n;
            int           i;
            txt = scld_pkg::KW_TEXT[k];
            n   = int'(scld_pkg::KW_LEN[k]);
            s   = "";
            for (i = 0; i < n; i++)
            begin
                s = {s, " "};
                s.putc(i, txt[8 * (n - 1 - i) +: 8]);
            end
            return s;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function void clear_line();
            kw_alive   = '1;
            tok_pos    = 0;
            phase      = scld_pkg::PH_SKIP_LEAD;
            digit_cnt  = 0;
            hh         = 0;
            mi         = 0;
            ss         = 0;
            dd         = 0;
            mo         = 0;
            yy         = 0;
            arg_bad    = 1'b0;
            line_len   = 0;
            overflowed = 1'b0;
        endfunction

        function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_len(int m, int y);
            case (m)
                2:           return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function longint days_to(int y, int m);
            longint d;
            int     i;
            d = 0;
            for (i = 1970; i < y; i++)
                d += is_leap(i) ? 366 : 365;
            for (i = 1; i < m; i++)
                d += month_len(i, y);
            return d;
        endfunction

        function void match_keyword(logic [7:0] c);
            string s;
            int    k;
            for (k = 0; k < scld_pkg::NUM_KW; k++)
            begin
                s = keyword(k);
                if (tok_pos >= s.len() || s[tok_pos] != c)
                    kw_alive[k] = 1'b0;
            end
            if (tok_pos < 31)
                tok_pos++;
        endfunction

        function void take_digit(logic [7:0] c);
            int d;
            if (digit_cnt >= 14)
            begin
                arg_bad = 1'b1;
                return;
            end
            if (c < scld_pkg::CHAR_0 || c > scld_pkg::CHAR_9)
            begin
                arg_bad = 1'b1;
                digit_cnt++;
                return;
            end
            d = int'(c - scld_pkg::CHAR_0);
            if (digit_cnt < 2)
                hh = hh * 10 + d;
            else if (digit_cnt < 4)
                mi = mi * 10 + d;
            else if (digit_cnt < 6)
                ss = ss * 10 + d;
            else if (digit_cnt < 8)
                dd = dd * 10 + d;
            else if (digit_cnt < 10)
                mo = mo * 10 + d;
            else
                yy = yy * 10 + d;
            digit_cnt++;
        endfunction

        function void close_line();
            line_result_t r;
            longint       t;
            string        s;
            int           k;
            r.command  = scld_pkg::CMD_NONE;
            r.status   = scld_pkg::TS_NONE;
            r.seconds  = '0;
            r.overflow = overflowed;
            if (!overflowed && phase != scld_pkg::PH_SKIP_LEAD)
            begin
                for (k = scld_pkg::NUM_KW - 1; k >= 0; k--)
                begin
                    s = keyword(k);
                    if (kw_alive[k] && s.len() == tok_pos)
                        r.command = 3'(k);
                end
            end
            if (r.command == scld_pkg::CMD_SET_CLOCK)
            begin
                r.status = scld_pkg::TS_BAD;
                if (phase == scld_pkg::PH_ARGUMENT && !arg_bad && digit_cnt >= 14 &&
                    mo >= 1 && mo <= 12 && yy >= 1970 && yy <= 2105)
                begin
                    t = (days_to(yy, mo) + dd - 1) * 86400 + hh * 3600 + mi * 60 + ss;
                    if (t >= 0 && t <= longint'(32'hFFFF_FFFF))
                    begin
                        r.status  = scld_pkg::TS_OK;
                        r.seconds = t[31:0];
                    end
                end
            end
            expected_lines.push_back(r);
            clear_line();
        endfunction

        function void accept_byte(logic [7:0] c);
            if (c == scld_pkg::CHAR_CR || c == scld_pkg::CHAR_LF)
            begin
                close_line();
                return;
            end
            if (overflowed)
                return;
            if (line_len >= scld_pkg::MAX_LINE - 1)
            begin
                overflowed = 1'b1;
                return;
            end
            line_len++;
            case (phase)
                scld_pkg::PH_SKIP_LEAD:
                    if (c != scld_pkg::CHAR_EQ)
                    begin
                        phase = scld_pkg::PH_COMMAND;
                        match_keyword(c);
                    end
                scld_pkg::PH_COMMAND:
                    if (c == scld_pkg::CHAR_EQ)
                        phase = scld_pkg::PH_SKIP_ARG;
                    else
                        match_keyword(c);
                scld_pkg::PH_SKIP_ARG:
                    if (c != scld_pkg::CHAR_EQ)
                    begin
                        phase = scld_pkg::PH_ARGUMENT;
                        take_digit(c);
                    end
                default:
                    if (digit_cnt != int'(scld_pkg::ARG_ENDED))
                    begin
                        if (c == scld_pkg::CHAR_EQ)
                        begin
                            if (digit_cnt != int'(scld_pkg::ARG_FULL))
                                arg_bad = 1'b1;
                            digit_cnt = int'(scld_pkg::ARG_ENDED);
                        end
                        else
                            take_digit(c);
                    end
            endcase
        endfunction

        function void compare_line(logic [39:0] w);
            line_result_t e;
            if (expected_lines.size() == 0)
            begin
                errors++;
                $error("result word with no line pending: %h", w);
                return;
            end
            e = expected_lines.pop_front();
            if (w[2:0] != e.command)
            begin
                errors++;
                $error("command: expected %0d, got %0d", e.command, w[2:0]);
            end
            if (w[4:3] != e.status)
            begin
                errors++;
                $error("time_status: expected %0d, got %0d", e.status, w[4:3]);
            end
            if (w[36:5] != e.seconds)
            begin
                errors++;
                $error("unix_time: expected %0d, got %0d", e.seconds, w[36:5]);
            end
            if (w[37] != e.overflow)
            begin
                errors++;
                $error("line_overflow: expected %0d, got %0d", e.overflow, w[37]);
            end
        endfunction

    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    line_scoreboard sb;
    int             bytes_sent   = 0;
    int             stall_cycles = 0;
    bit             steady       = 1'b0;
    bit             hold_req     = 1'b0;

    serial_command_line_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.accept_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.compare_line(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[serial_command_line_decoder] ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic put_eqs(input int n);
        repeat (n) send_byte(scld_pkg::CHAR_EQ);
    endtask

    task automatic put_keyword(input logic [2:0] code);
        put_text(sb.keyword(int'(code)));
    endtask

    task automatic put_num(input int v, input int nd);
        int p;
        int i;
        p = 1;
        for (i = 1; i < nd; i++)
            p *= 10;
        for (i = 0; i < nd; i++)
        begin
            send_byte(scld_pkg::CHAR_0 + 8'((v / p) % 10));
            p /= 10;
        end
    endtask

    task automatic put_set(input string arg);
        put_keyword(scld_pkg::CMD_SET_CLOCK);
        send_byte(scld_pkg::CHAR_EQ);
        put_text(arg);
        send_byte(scld_pkg::CHAR_CR);
    endtask

    task automatic put_term();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            send_byte(scld_pkg::CHAR_CR);
        else if (r < 8)
            send_byte(scld_pkg::CHAR_LF);
        else
        begin
            send_byte(scld_pkg::CHAR_CR);
            send_byte(scld_pkg::CHAR_LF);
        end
    endtask

    task automatic put_time_arg();
        int hh, mi, ss, dd, mo, yy, r;
        hh = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
        mi = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
        ss = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
        dd = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 28);
        mo = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
        r  = $urandom_range(9);
        if (r == 0)
            yy = $urandom_range(9999);
        else if (r == 1)
            yy = $urandom_range(1960, 2115);
        else
            yy = $urandom_range(1970, 2105);
        put_num(hh, 2);
        put_num(mi, 2);
        put_num(ss, 2);
        put_num(dd, 2);
        put_num(mo, 2);
        put_num(yy, 4);
    endtask

    task automatic put_bad_arg();
        int n, pos, i;
        n   = $urandom_range(8, 16);
        pos = $urandom_range(n);
        for (i = 0; i < n; i++)
        begin
            if (i == pos)
                send_byte(8'($urandom_range(33, 126)));
            else
                send_byte(scld_pkg::CHAR_0 + 8'($urandom_range(9)));
        end
    endtask

    task automatic random_line();
        int    kind, k, n, i, pos;
        string s;
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            put_eqs($urandom_range(2));
            k = ($urandom_range(9) < 4) ? int'(scld_pkg::CMD_SET_CLOCK) : $urandom_range(5);
            put_text(sb.keyword(k));
            if (k == int'(scld_pkg::CMD_SET_CLOCK))
            begin
                if ($urandom_range(19) != 0)
                begin
                    put_eqs($urandom_range(1, 3));
                    if ($urandom_range(9) < 7)
                        put_time_arg();
                    else
                        put_bad_arg();
                end
            end
            else if ($urandom_range(4) == 0)
            begin
                put_eqs(1);
                put_text("ARG");
            end
            if ($urandom_range(9) == 0)
            begin
                put_eqs($urandom_range(1, 2));
                put_text("X9");
            end
        end
        else if (kind < 70)
        begin
            k   = $urandom_range(5);
            s   = sb.keyword(k);
            pos = $urandom_range(s.len() - 1);
            case ($urandom_range(2))
                0:
                    for (i = 0; i < s.len() - 1; i++)
                        send_byte(s[i]);
                1:
                begin
                    put_text(s);
                    send_byte(8'($urandom_range(33, 126)));
                end
                default:
                    for (i = 0; i < s.len(); i++)
                        send_byte((i == pos) ? (s[i] ^ 8'h20) : s[i]);
            endcase
        end
        else if (kind < 85)
        begin
            n = $urandom_range(20);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(255)));
        end
        else if (kind < 97)
            put_eqs($urandom_range(3));
        else
        begin
            n = $urandom_range(95, 130);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(32, 126)));
        end
        put_term();
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put_keyword(scld_pkg::CMD_GET_EPOCH);
        send_byte(scld_pkg::CHAR_CR);
        put_keyword(scld_pkg::CMD_READ_CLOCK);
        send_byte(scld_pkg::CHAR_LF);
        put_text("SAMPLE");
        send_byte(scld_pkg::CHAR_CR);
        send_byte(scld_pkg::CHAR_LF);
        put_text("==START");
        send_byte(scld_pkg::CHAR_LF);
        put_text("STOP=extra==tok");
        send_byte(scld_pkg::CHAR_CR);
        send_byte(scld_pkg::CHAR_CR);
        put_text("===");
        send_byte(scld_pkg::CHAR_LF);
        put_text("stop");
        send_byte(scld_pkg::CHAR_CR);
        send_byte(8'h00);
        put_text("STOP");
        send_byte(scld_pkg::CHAR_CR);
        put_text("STA");
        send_byte(8'hFF);
        send_byte(scld_pkg::CHAR_CR);
        put_keyword(scld_pkg::CMD_SET_CLOCK);
        send_byte(scld_pkg::CHAR_CR);
        put_set("00000001011970");
        put_keyword(scld_pkg::CMD_SET_CLOCK);
        put_eqs(3);
        put_text("06281531122105=x=y");
        send_byte(scld_pkg::CHAR_LF);
        put_set("24000000011970");
        put_set("00000000011970");
        put_set("99999999122105");
        put_set("0000000101197");
        put_set("000000010119700");
        put_set("0000000101197A");
        put_set("00000001131999");
        put_set("00000001001999");
        put_set("00000001011969");
        put_set("00000001012106");
        put_set("12345629022000");
        put_set("00000001012100=");
        put_set("0000000101210=");
        put_text("STOP");
        put_eqs(95);
        send_byte(scld_pkg::CHAR_CR);
        put_text("STOP");
        put_eqs(96);
        send_byte(scld_pkg::CHAR_CR);

        // The receiver stalls while lines keep coming, so the block backs up.
        hold_req = 1'b1;
        repeat (8)
        begin
            put_text("START");
            send_byte(scld_pkg::CHAR_CR);
        end
        wait_drain();

        while (bytes_sent < ITEM_TARGET)
        begin
            steady = (bytes_sent >= 700 && bytes_sent < 1000);
            random_line();
        end
        steady = 1'b0;
        wait_drain();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("[serial_command_line_decoder] OK");
        else
            $display("[serial_command_line_decoder] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/scld_pkg.sv
rtl/core/scld_ctrl.sv
rtl/core/scld_datapath.sv
rtl/core/serial_command_line_decoder.sv
tb/tb_serial_command_line_decoder.sv
